/* sv/kfs_pkg.sv */
// kfs_pkg: shared types, sizes and constant tables of the keyframe channel sampler
// used by every module of the block; depends on nothing else
`default_nettype none

package kfs_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int KEY_AW     = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int BONE_W     = 10;
  localparam int KIND_W     = 2;
  localparam int RATIO_W    = 17;
  localparam int CORD_W     = 34;
  localparam int CORD_STEPS = 16;
  localparam int CORD_IW    = $clog2(CORD_STEPS);
  localparam int DIV_NW     = CORD_W + 14;
  localparam int DIV_DW     = 32;
  localparam int DIV_CW     = $clog2(DIV_NW);
  localparam int SQ_W       = 58;

  // raw kind codes on the input tuser
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;
  localparam logic [28:0] ONE_Q28   = 29'd268435456;
  localparam logic [28:0] SLERP_THR = 29'd268435456 - 29'd2684;
  localparam logic signed [CORD_W-1:0] CORD_KINV = 34'sd652032874;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_kind_t;

  // same bit order as the input tdata: time in the lowest bits
  typedef struct packed {
    logic [2:0][31:0] scale;
    logic [3:0][15:0] rot;
    logic [2:0][31:0] pos;
    logic [31:0]      tm;
  } key_t;

  typedef struct packed {
    cmd_kind_t kind;
    key_t      key;
  } cmd_t;

  typedef struct packed {
    logic [2:0][31:0]  scale;
    logic [3:0][15:0]  rot;
    logic [2:0][31:0]  pos;
    logic [BONE_W-1:0] bone;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int IN_DATA_W  = $bits(key_t);
  localparam int OUT_DATA_W = (($bits(res_t) + 7) / 8) * 8;

  // arctangent of 2^-i in Q30 radians
  function automatic logic signed [CORD_W-1:0] atan_q30(input logic [CORD_IW-1:0] i);
    logic signed [CORD_W-1:0] v;
    case (i)
      4'd0:    v = 34'sd843314856;
      4'd1:    v = 34'sd497837829;
      4'd2:    v = 34'sd263043836;
      4'd3:    v = 34'sd133525158;
      4'd4:    v = 34'sd67021686;
      4'd5:    v = 34'sd33543515;
      4'd6:    v = 34'sd16775850;
      4'd7:    v = 34'sd8388437;
      4'd8:    v = 34'sd4194282;
      4'd9:    v = 34'sd2097149;
      4'd10:   v = 34'sd1048575;
      4'd11:   v = 34'sd524287;
      4'd12:   v = 34'sd262143;
      4'd13:   v = 34'sd131071;
      4'd14:   v = 34'sd65535;
      4'd15:   v = 34'sd32767;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/kfs_front.sv */
// kfs_front: input side of the sampler, decodes the kind of each beat into a command
// depends on kfs_pkg
`default_nettype none

module kfs_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kfs_pkg::IN_DATA_W-1:0] s_tdata,   // time_req, pos_x..z, rot_x..w, scale_x..z
  input  logic [kfs_pkg::KIND_W-1:0]    s_tuser,   // kind
  output logic                          push_valid,
  input  logic                          push_ready,
  output kfs_pkg::cmd_t                 push_cmd
);
  import kfs_pkg::*;

  logic kind_ok;

  always_comb begin
    kind_ok       = 1'b1;
    push_cmd.kind = CMD_APPEND;
    case (s_tuser)
      KIND_APPEND: push_cmd.kind = CMD_APPEND;
      KIND_QUERY:  push_cmd.kind = CMD_QUERY;
      KIND_CLEAR:  push_cmd.kind = CMD_CLEAR;
      default:     kind_ok = 1'b0;
    endcase
  end

  assign push_cmd.key = key_t'(s_tdata);
  // unused kinds are taken and dropped here
  assign s_tready     = push_ready;
  assign push_valid   = s_tvalid && kind_ok;

endmodule

`default_nettype wire

/* sv/kfs_queue.sv */
// kfs_queue: short command queue between the front and the back of the sampler
// depends on kfs_pkg
`default_nettype none

module kfs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  kfs_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output kfs_pkg::cmd_t pop_cmd
);
  import kfs_pkg::*;

  cmd_t             slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != (QAW + 1)'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/kfs_div.sv */
// kfs_div: restoring divider, one quotient bit per cycle, shared by the back end
// depends on kfs_pkg
`default_nettype none

module kfs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kfs_pkg::DIV_NW-1:0] num,
  input  logic [kfs_pkg::DIV_DW-1:0] den,
  output kfs_pkg::div_stat_t         stat,
  output logic [kfs_pkg::DIV_NW-1:0] quo
);
  import kfs_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem, quo[DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, dreg};
  assign fits    = (rem_sh >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        rem       <= '0;
        quo       <= num;
        dreg      <= den;
      end else if (stat.busy) begin
        rem <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], fits};
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/kfs_back.sv */
// kfs_back: key store and query sequencer (search, ratio, lerp, slerp via isqrt and cordic)
// depends on kfs_pkg and kfs_div
`default_nettype none

module kfs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  kfs_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic [kfs_pkg::BONE_W-1:0] bone_id,
  output logic                       res_valid,
  input  logic                       res_ready,
  output kfs_pkg::res_t              res,
  output logic                       res_empty
);
  import kfs_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_SRCH  = 23'h000002,
    S_LDA   = 23'h000004,
    S_LDB   = 23'h000008,
    S_LDW   = 23'h000010,
    S_RDIV  = 23'h000020,
    S_LERPM = 23'h000040,
    S_LERPA = 23'h000080,
    S_DOT   = 23'h000100,
    S_SQR   = 23'h000200,
    S_SQM   = 23'h000400,
    S_SQRT  = 23'h000800,
    S_ATI   = 23'h001000,
    S_ATAN  = 23'h002000,
    S_OMG   = 23'h004000,
    S_OMG2  = 23'h008000,
    S_SIN   = 23'h010000,
    S_SIND  = 23'h020000,
    S_WDIV  = 23'h040000,
    S_ROTA  = 23'h080000,
    S_ROTB  = 23'h100000,
    S_ROTC  = 23'h200000,
    S_OUT   = 23'h400000
  } state_t;

  state_t state;

  key_t              key_mem [MAX_KEYS];
  key_t              rd_data;
  logic [KEY_AW-1:0] rd_addr;
  key_t              ka;
  key_t              kb;

  logic [CNT_W-1:0]  key_count;
  logic [CNT_W-1:0]  idx;
  logic              pend;
  logic [KEY_AW-1:0] pend_idx;
  logic [KEY_AW-1:0] piv;
  logic [31:0]       qtime;
  logic              has_next;
  logic              append_ok;

  logic [RATIO_W-1:0] ratio;
  logic [RATIO_W-1:0] w0;
  logic [RATIO_W-1:0] w1;
  logic [RATIO_W-1:0] qclamp;

  logic [2:0]          lj;
  logic [1:0]          lsel;
  logic [31:0]         la;
  logic [31:0]         lb;
  logic signed [32:0]  ldiff;
  logic signed [50:0]  lprod;

  logic [1:0]          qk;
  logic signed [33:0]  dot;
  logic signed [33:0]  mag;
  logic                dneg;
  logic [28:0]         dabs;
  logic signed [15:0]  qa_s;
  logic signed [15:0]  qb_s;
  logic signed [16:0]  q1;

  logic [SQ_W-1:0]     sq_v;
  logic [SQ_W-1:0]     sq_res;
  logic [SQ_W-1:0]     sq_bit;
  logic [SQ_W-1:0]     sq_try;

  logic signed [CORD_W-1:0]    cx;
  logic signed [CORD_W-1:0]    cy;
  logic signed [CORD_W-1:0]    cz;
  logic signed [CORD_W-1:0]    cx_sh;
  logic signed [CORD_W-1:0]    cy_sh;
  logic [CORD_IW-1:0]          ci;
  logic                        sin_sel;
  logic signed [CORD_W+17:0]   oprod;
  logic signed [CORD_W-1:0]    a1;
  logic signed [CORD_W-1:0]    ang1;

  logic signed [33:0]  pa;
  logic signed [34:0]  pb;
  logic signed [35:0]  rsum;
  logic signed [35:0]  rsh;
  logic [15:0]         rsat;

  res_t                wres;
  logic                wempty;
  logic                out_load;

  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  div_stat_t           div_stat;
  logic [DIV_NW-1:0]   div_quo;

  kfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign append_ok = (key_count < CNT_W'(MAX_KEYS));
  assign has_next  = ((CNT_W'(piv) + CNT_W'(1)) < key_count);
  assign out_load  = (state == S_OUT) && (!res_valid || res_ready);
  assign qclamp    = (div_quo > DIV_NW'(RATIO_ONE)) ? RATIO_ONE : div_quo[RATIO_W-1:0];

  always_comb begin
    case (state)
      S_SRCH:  rd_addr = idx[KEY_AW-1:0];
      S_LDA:   rd_addr = piv;
      default: rd_addr = piv + KEY_AW'(1);
    endcase
  end

  // lerp operand select: steps 0..2 position, 3..5 scale
  always_comb begin
    lsel = (lj < 3'd3) ? lj[1:0] : 2'(lj - 3'd3);
    la   = (lj < 3'd3) ? ka.pos[lsel] : ka.scale[lsel];
    lb   = (lj < 3'd3) ? kb.pos[lsel] : kb.scale[lsel];
  end
  assign ldiff = $signed({lb[31], lb}) - $signed({la[31], la});

  assign qa_s = $signed(ka.rot[qk]);
  assign qb_s = $signed(kb.rot[qk]);
  assign q1   = dneg ? -$signed({qb_s[15], qb_s}) : $signed({qb_s[15], qb_s});
  assign mag  = dot[33] ? -dot : dot;

  assign sq_try = sq_res + sq_bit;
  assign cx_sh  = cx >>> ci;
  assign cy_sh  = cy >>> ci;
  assign a1     = $signed(oprod[CORD_W+15:16]);

  always_comb begin
    rsum = 36'(pa) + 36'(pb) + 36'sd32768;
    rsh  = rsum >>> 16;
    if (rsh > 36'sd32767) begin
      rsat = 16'h7fff;
    end else if (rsh < -36'sd32768) begin
      rsat = 16'h8000;
    end else begin
      rsat = rsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == CMD_APPEND) && append_ok) begin
      key_mem[key_count[KEY_AW-1:0]] <= cmd.key;
    end
    rd_data <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              CMD_APPEND: begin
                if (append_ok) begin
                  key_count <= key_count + CNT_W'(1);
                end
              end
              CMD_CLEAR: key_count <= '0;
              CMD_QUERY: begin
                qtime <= cmd.key.tm;
                wres  <= '0;
                if (key_count == '0) begin
                  wempty <= 1'b1;
                  state  <= S_OUT;
                end else begin
                  wempty <= 1'b0;
                  idx    <= '0;
                  pend   <= 1'b0;
                  piv    <= '0;
                  state  <= S_SRCH;
                end
              end
              default: ;
            endcase
          end
        end
        // one read issued per cycle, each compared in the next cycle
        S_SRCH: begin
          if (idx < key_count) begin
            pend     <= 1'b1;
            pend_idx <= idx[KEY_AW-1:0];
            idx      <= idx + CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && (rd_data.tm <= qtime)) begin
            piv <= pend_idx;
          end
          if (!pend && (idx == key_count)) begin
            state <= S_LDA;
          end
        end
        S_LDA: state <= S_LDB;
        S_LDB: begin
          ka    <= rd_data;
          state <= S_LDW;
        end
        S_LDW: begin
          kb <= rd_data;
          if (!has_next) begin
            wres.pos   <= ka.pos;
            wres.rot   <= ka.rot;
            wres.scale <= ka.scale;
            state      <= S_OUT;
          end else if ((qtime >= ka.tm) && (rd_data.tm > ka.tm)) begin
            div_start <= 1'b1;
            div_num   <= DIV_NW'({qtime - ka.tm, 16'h0000});
            div_den   <= rd_data.tm - ka.tm;
            state     <= S_RDIV;
          end else begin
            ratio <= '0;
            lj    <= '0;
            state <= S_LERPM;
          end
        end
        S_RDIV: begin
          if (div_stat.done) begin
            ratio <= qclamp;
            lj    <= '0;
            state <= S_LERPM;
          end
        end
        S_LERPM: begin
          lprod <= ldiff * $signed({1'b0, ratio});
          state <= S_LERPA;
        end
        S_LERPA: begin
          if (lj < 3'd3) begin
            wres.pos[lsel] <= la + lprod[47:16];
          end else begin
            wres.scale[lsel] <= la + lprod[47:16];
          end
          if (lj == 3'd5) begin
            dot   <= '0;
            qk    <= '0;
            state <= S_DOT;
          end else begin
            lj    <= lj + 3'd1;
            state <= S_LERPM;
          end
        end
        S_DOT: begin
          dot <= dot + 34'(qa_s * qb_s);
          qk  <= qk + 2'd1;
          if (qk == 2'd3) begin
            state <= S_SQR;
          end
        end
        // shortest path: flip the second quaternion on a negative dot
        S_SQR: begin
          dneg  <= dot[33];
          dabs  <= (mag > 34'sd268435456) ? ONE_Q28 : mag[28:0];
          w0    <= RATIO_ONE - ratio;
          w1    <= ratio;
          state <= S_SQM;
        end
        S_SQM: begin
          if (dabs >= SLERP_THR) begin
            qk    <= '0;
            state <= S_ROTA;
          end else begin
            sq_v   <= (SQ_W'(1) << 56) - (SQ_W'(dabs) * SQ_W'(dabs));
            sq_res <= '0;
            sq_bit <= SQ_W'(1) << 56;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= S_ATI;
          end
        end
        S_ATI: begin
          if (sq_res == '0) begin
            qk    <= '0;
            state <= S_ROTA;
          end else begin
            cx    <= CORD_W'(dabs);
            cy    <= CORD_W'(sq_res[28:0]);
            cz    <= '0;
            ci    <= '0;
            state <= S_ATAN;
          end
        end
        S_ATAN: begin
          if (cy > 0) begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + atan_q30(ci);
          end else begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - atan_q30(ci);
          end
          ci <= ci + CORD_IW'(1);
          if (ci == CORD_IW'(CORD_STEPS - 1)) begin
            state <= S_OMG;
          end
        end
        S_OMG: begin
          oprod <= cz * $signed({1'b0, ratio});
          state <= S_OMG2;
        end
        S_OMG2: begin
          ang1    <= a1;
          cz      <= cz - a1;
          cx      <= CORD_KINV;
          cy      <= '0;
          ci      <= '0;
          sin_sel <= 1'b0;
          state   <= S_SIN;
        end
        S_SIN: begin
          if (cz >= 0) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - atan_q30(ci);
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + atan_q30(ci);
          end
          ci <= ci + CORD_IW'(1);
          if (ci == CORD_IW'(CORD_STEPS - 1)) begin
            state <= S_SIND;
          end
        end
        S_SIND: begin
          div_start <= 1'b1;
          div_num   <= cy[CORD_W-1] ? '0 : {cy, 14'h0000};
          div_den   <= DIV_DW'(sq_res[28:0]);
          state     <= S_WDIV;
        end
        S_WDIV: begin
          if (div_stat.done) begin
            if (!sin_sel) begin
              w0      <= qclamp;
              sin_sel <= 1'b1;
              cx      <= CORD_KINV;
              cy      <= '0;
              cz      <= ang1;
              ci      <= '0;
              state   <= S_SIN;
            end else begin
              w1    <= qclamp;
              qk    <= '0;
              state <= S_ROTA;
            end
          end
        end
        S_ROTA: begin
          pa    <= $signed({1'b0, w0}) * qa_s;
          state <= S_ROTB;
        end
        S_ROTB: begin
          pb    <= $signed({1'b0, w1}) * q1;
          state <= S_ROTC;
        end
        S_ROTC: begin
          wres.rot[qk] <= rsat;
          qk           <= qk + 2'd1;
          state        <= (qk == 2'd3) ? S_OUT : S_ROTA;
        end
        S_OUT: begin
          if (out_load) begin
            res       <= wres;
            res.bone  <= bone_id;
            res_empty <= wempty;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table size");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
  a_srch_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (key_count != '0))
    else $error("search on an empty table");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (res_valid && (state == S_IDLE)))
    else $error("result load lost");
`endif

endmodule

`default_nettype wire

/* sv/keyframe_channel_sampler_core.sv */
// keyframe_channel_sampler_core: top level of the keyframe channel sampler
// depends on kfs_pkg, kfs_front, kfs_queue, kfs_back
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: key or query time, tuser: kind
//  m_*      out  m_tvalid/m_tready  tdata: sampled bone channel, tuser: empty_res
//  cfg_*    in   cfg_valid/cfg_ready cfg_data: bone_id
//
// append and clear are handled in the back end's idle state after the two-entry command queue
// a query scans every key; when the chosen key has no successor its values are returned,
// otherwise up to three divides, a 29-step isqrt and up to three 16-step cordic runs
// on one shared sequencer produce the sample
// reset clears the key count; key storage is not cleared and there is no sweep
// the front keeps taking beats while a result waits for m_tready, until the command queue is full
`default_nettype none

module keyframe_channel_sampler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [kfs_pkg::IN_DATA_W-1:0]  s_tdata,   // time_req, pos_x..z, rot_x..w, scale_x..z
  input  logic [kfs_pkg::KIND_W-1:0]     s_tuser,   // kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [kfs_pkg::OUT_DATA_W-1:0] m_tdata,   // out_bone, out_pos_x..z, out_rot_x..w,
                                                    // out_scale_x..z, zero fill
  output logic                           m_tuser,   // empty_res
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kfs_pkg::BONE_W-1:0]     cfg_data
);
  import kfs_pkg::*;

  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic              pop_valid;
  logic              pop;
  cmd_t              pop_cmd;
  logic [BONE_W-1:0] bone_id;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_id <= '0;
    end else if (cfg_valid) begin
      bone_id <= cfg_data;
    end
  end

  kfs_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  kfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  kfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .bone_id   (bone_id),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res),
    .res_empty (m_tuser)
  );

  assign m_tdata = OUT_DATA_W'(res);

endmodule

`default_nettype wire

/* tb/tb_keyframe_channel_sampler_core.sv */
// tb_keyframe_channel_sampler_core: self-checking bench for the keyframe channel sampler
// predicts every query sample in-bench; depends on kfs_pkg and keyframe_channel_sampler_core
`timescale 1ns / 100ps

module tb_keyframe_channel_sampler_core;
  import kfs_pkg::*;

  localparam int TBL = 64;
  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE = 600;

  typedef struct {
    logic [1:0] kind;
    key_t       key;
  } cmd_item_t;

  typedef struct {
    logic [BONE_W-1:0] bone;
    logic              empty;
    logic [31:0]       pos [3];
    logic [15:0]       rot [4];
    logic [31:0]       scl [3];
  } sample_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [BONE_W-1:0] cfg_data = '0;

  keyframe_channel_sampler_core u_top (.*);

  always #10 clk = ~clk;

  cmd_item_t cmd_q[$];
  cmd_item_t cur_cmd;
  sample_t   sample_q[$];
  int        errors = 0;
  int        send_idle = 0, recv_stall = 0;
  int        quiet_cycles = 0;

  // predictor state
  logic [BONE_W-1:0] bone_reg = '0;
  int          n_keys = 0;
  logic [31:0] k_time [TBL];
  longint      k_pos [TBL][3];
  longint      k_rot [TBL][4];
  longint      k_scl [TBL][3];

  const longint atan_tab [16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767};

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint z);
    longint x, y, nx, ny;
    x = 652032874; y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  function automatic longint slerp_weight(longint ang, longint s);
    longint sn, w;
    sn = rot_sine(ang);
    if (sn < 0) sn = 0;
    w = (sn * 16384) / s;
    return (w > 65536) ? 65536 : w;
  endfunction

  function automatic longint mix(longint a, longint b, longint r);
    return a + (((b - a) * r) >>> 16);
  endfunction

  // applies one accepted command to the key table, queues a sample for queries
  function automatic void sample_channel(cmd_item_t c);
    sample_t e;
    int p;
    longint r, dot, w0, w1, s, omega, a1, v;
    longint q1 [4];
    logic [31:0] t, t0, t1;
    t = c.key.tm;
    if (c.kind == KIND_APPEND) begin
      if (n_keys < TBL) begin
        k_time[n_keys] = t;
        for (int k = 0; k < 3; k++) begin
          k_pos[n_keys][k] = longint'($signed(c.key.pos[k]));
          k_scl[n_keys][k] = longint'($signed(c.key.scale[k]));
        end
        for (int k = 0; k < 4; k++) k_rot[n_keys][k] = longint'($signed(c.key.rot[k]));
        n_keys++;
      end
      return;
    end
    if (c.kind == KIND_CLEAR) begin
      n_keys = 0;
      return;
    end
    if (c.kind != KIND_QUERY) return;
    e.bone = bone_reg;
    e.empty = (n_keys == 0);
    for (int k = 0; k < 3; k++) begin e.pos[k] = '0; e.scl[k] = '0; end
    for (int k = 0; k < 4; k++) e.rot[k] = '0;
    if (n_keys > 0) begin
      p = 0;
      for (int i = 0; i < n_keys; i++) if (k_time[i] <= t) p = i;
      if (p + 1 < n_keys) begin
        t0 = k_time[p]; t1 = k_time[p+1];
        r = 0;
        if (t >= t0 && t1 > t0) begin
          r = longint'(((64'(t - t0)) << 16) / 64'(t1 - t0));
          if (r > 65536) r = 65536;
        end
        for (int k = 0; k < 3; k++) begin
          e.pos[k] = 32'(mix(k_pos[p][k], k_pos[p+1][k], r));
          e.scl[k] = 32'(mix(k_scl[p][k], k_scl[p+1][k], r));
        end
        dot = 0;
        for (int k = 0; k < 4; k++) dot += k_rot[p][k] * k_rot[p+1][k];
        for (int k = 0; k < 4; k++) q1[k] = (dot < 0) ? -k_rot[p+1][k] : k_rot[p+1][k];
        if (dot < 0) dot = -dot;
        if (dot > 268435456) dot = 268435456;
        w0 = 65536 - r;
        w1 = r;
        if (dot < 268435456 - 2684) begin
          s = int_sqrt((64'd1 << 56) - 64'(dot) * 64'(dot));
          if (s > 0) begin
            omega = vec_angle(s, dot);
            a1 = (omega * r) >>> 16;
            w0 = slerp_weight(omega - a1, s);
            w1 = slerp_weight(a1, s);
          end
        end
        for (int k = 0; k < 4; k++) begin
          v = (w0 * k_rot[p][k] + w1 * q1[k] + 32768) >>> 16;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          e.rot[k] = 16'(v);
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          e.pos[k] = 32'(k_pos[p][k]);
          e.scl[k] = 32'(k_scl[p][k]);
        end
        for (int k = 0; k < 4; k++) e.rot[k] = 16'(k_rot[p][k]);
      end
    end
    sample_q.push_back(e);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) sample_channel(cur_cmd);
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= cur_cmd.key;
        s_tuser <= cur_cmd.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  function automatic void chk(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, fname, want, got);
    end
  endfunction

  // output monitor
  always @(posedge clk) begin
    res_t act;
    sample_t e;
    if (!rst && m_tvalid && m_tready) begin
      act = m_tdata[$bits(res_t)-1:0];
      if (sample_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: actual %h", $time, m_tdata);
      end else begin
        e = sample_q.pop_front();
        chk("out_bone", 32'(e.bone), 32'(act.bone));
        chk("empty_res", 32'(e.empty), 32'(m_tuser));
        for (int k = 0; k < 3; k++) begin
          chk($sformatf("out_pos[%0d]", k), e.pos[k], act.pos[k]);
          chk($sformatf("out_scale[%0d]", k), e.scl[k], act.scale[k]);
        end
        for (int k = 0; k < 4; k++) chk($sformatf("out_rot[%0d]", k), 32'(e.rot[k]),
                                        32'(act.rot[k]));
      end
    end
    m_tready <= !rst && ($urandom_range(99) >= recv_stall);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("keyframe_channel_sampler_core test failed");
      $finish;
    end
  end

  function automatic void push_cmd(logic [1:0] kind, key_t key);
    cmd_item_t c;
    c.kind = kind;
    c.key = key;
    cmd_q.push_back(c);
  endfunction

  function automatic key_t rand_key(logic [31:0] t);
    key_t k;
    k.tm = t;
    for (int i = 0; i < 3; i++) begin
      k.pos[i] = $urandom;
      k.scale[i] = $urandom;
    end
    for (int i = 0; i < 4; i++) k.rot[i] = $urandom;
    return k;
  endfunction

  task automatic drain();
    while (cmd_q.size() != 0 || s_tvalid || sample_q.size() != 0) @(posedge clk);
    // appends and clears leave no result behind, so give the back end time to finish
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bone(logic [BONE_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bone_reg = v;
  endtask

  task automatic directed_items();
    key_t a, b;
    a = rand_key(32'd100);
    a.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    a.scale = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    a.rot = '{16'h8000, 16'h7FFF, 16'h0, 16'h4000};
    b = a;
    b.tm = 32'hFFFF_FFFF;
    b.pos = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    b.scale = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
    b.rot = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'hC000};
    push_cmd(KIND_QUERY, rand_key(32'd5));          // empty table
    push_cmd(KIND_APPEND, a);
    push_cmd(KIND_QUERY, rand_key(32'd100));        // one key
    push_cmd(KIND_QUERY, rand_key(32'd0));          // before first key
    push_cmd(KIND_APPEND, b);
    push_cmd(KIND_QUERY, rand_key(32'h8000_0000));
    push_cmd(KIND_QUERY, rand_key(32'hFFFF_FFFF));  // at last key
    push_cmd(KIND_APPEND, rand_key(32'd50));        // out of time order
    push_cmd(KIND_QUERY, rand_key(32'd60));
    push_cmd(KIND_QUERY, rand_key(32'd200));
    push_cmd(2'd3, rand_key($urandom));             // unused kind
    push_cmd(KIND_CLEAR, rand_key($urandom));
    push_cmd(KIND_QUERY, rand_key(32'd100));
    a.tm = 32'd1000;
    push_cmd(KIND_APPEND, a);
    a.tm = 32'd3000;                                // same quaternion, near-linear path
    push_cmd(KIND_APPEND, a);
    push_cmd(KIND_QUERY, rand_key(32'd2000));
    push_cmd(KIND_CLEAR, rand_key($urandom));
  endtask

  task automatic random_items(int quota);
    int made, n, sel;
    logic [31:0] t, t_lo;
    key_t k, prev;
    made = 0;
    while (made < quota) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        push_cmd(KIND_CLEAR, rand_key($urandom)); made++;
      end else if (sel < 7) begin
        push_cmd(2'd3, rand_key($urandom));
      end else if (sel < 12) begin
        push_cmd(KIND_APPEND, rand_key($urandom)); made++;
      end else if (sel < 16) begin
        push_cmd(KIND_QUERY, rand_key($urandom)); made++;
      end else begin
        if ($urandom_range(1)) begin push_cmd(KIND_CLEAR, rand_key($urandom)); made++; end
        n = ($urandom_range(24) == 0) ? 67 : $urandom_range(1, 5);
        t = $urandom_range(32'hF000_0000, 0);
        t_lo = t;
        prev = rand_key(t);
        for (int i = 0; i < n; i++) begin
          k = rand_key(t);
          case ($urandom_range(3))
            0: k.rot = prev.rot;
            1: for (int j = 0; j < 4; j++) k.rot[j] = -prev.rot[j];
            2: for (int j = 0; j < 4; j++) k.rot[j] = prev.rot[j] + 16'($urandom_range(63));
            default: ;
          endcase
          push_cmd(KIND_APPEND, k); made++;
          prev = k;
          t = t + (($urandom_range(7) == 0) ? 0 : $urandom_range(1 << 20, 1));
        end
        for (int i = 0; i < $urandom_range(2, 5); i++) begin
          push_cmd(KIND_QUERY, rand_key($urandom_range(t + 100, t_lo - 100))); made++;
        end
      end
    end
  endtask

  initial begin
    int idle_s [4] = '{0, 57, 0, 8};
    int stall_m [4] = '{0, 0, 57, 8};
    logic [BONE_W-1:0] bones [4];
    bones = '{10'h3FF, 10'h000, 10'($urandom), 10'($urandom)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_bone(10'h3FF);
    directed_items();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_bone(bones[ph]);
      send_idle = idle_s[ph];
      recv_stall = stall_m[ph];
      random_items(55);
      // sender holds back until every sample is out
      while (cmd_q.size() != 0 || s_tvalid || sample_q.size() != 0) @(posedge clk);
      random_items(55);
      drain();
    end
    if (errors == 0) begin
      $display("keyframe_channel_sampler_core test passed");
    end else begin
      $display("keyframe_channel_sampler_core test failed");
    end
    $finish;
  end

endmodule
